// ===== hw/rtl/ufd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufd_pkg
// shared types and constants for the utf-8 stream decoder
// ----------------------------------------------------------------------------
package ufd_pkg;

  localparam int unsigned CP_W     = 27;   // code point width
  localparam int unsigned PEND_W   = 3;    // continuation count width
  localparam int unsigned Q_DEPTH  = 2;    // front to back queue depth
  localparam int unsigned Q_PTR_W  = 1;
  localparam int unsigned Q_CNT_W  = 2;

  // one classified byte handed from front to back
  typedef struct packed {
    logic [CP_W-1:0] contrib;    // bits this byte adds, already in place
    logic            start;      // byte is a lead: drop earlier bits
    logic            emit;       // sequence completes or string ends
    logic            last_char;
    logic            truncated;
  } ufd_item_t;

endpackage

// ===== hw/rtl/ufd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufd_front
// classifies each byte against the continuation count and aligns its bits
// ----------------------------------------------------------------------------
module ufd_front import ufd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,        // byte accepted this cycle
  input  logic [7:0]        byte_in,
  input  logic              eos_in,
  output ufd_item_t         item,
  output logic [PEND_W-1:0] pending
);

  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [PEND_W-1:0] due;
  logic [7:0]        bits;
  logic [CP_W-1:0]   wide;

  always_comb begin
    bits = 8'd0;
    due  = '0;
    if (pend_r == '0) begin
      if ((byte_in & 8'h80) == 8'h00) begin
        bits = byte_in & 8'h7F;
        due  = 3'd0;
      end else if ((byte_in & 8'hE0) == 8'hC0) begin
        bits = byte_in & 8'h1F;
        due  = 3'd1;
      end else if ((byte_in & 8'hF0) == 8'hE0) begin
        bits = byte_in & 8'h0F;
        due  = 3'd2;
      end else if ((byte_in & 8'hF8) == 8'hF0) begin
        bits = byte_in & 8'h07;
        due  = 3'd3;
      end else begin
        bits = byte_in & 8'h07;
        due  = 3'd4;
      end
    end else begin
      // continuation, top bits unchecked
      bits = byte_in & 8'h3F;
      due  = pend_r - 3'd1;
      if (due > 3'd4) begin
        due = 3'd4;
      end
    end
  end

  always_comb begin
    wide = {{(CP_W-8){1'b0}}, bits};
    case (due)
      3'd0:    item.contrib = wide;
      3'd1:    item.contrib = wide << 6;
      3'd2:    item.contrib = wide << 12;
      3'd3:    item.contrib = wide << 18;
      default: item.contrib = wide << 24;
    endcase
    item.start     = (pend_r == '0);
    item.emit      = (due == '0) || eos_in;
    item.last_char = eos_in;
    item.truncated = eos_in && (due != '0);
    pend_nxt       = item.emit ? '0 : due;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (take) begin
      pend_r <= pend_nxt;
    end
  end

  assign pending = pend_r;

endmodule

// ===== hw/rtl/ufd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufd_queue
// two-entry fifo between classifier and assembler
// ----------------------------------------------------------------------------
module ufd_queue import ufd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ufd_item_t          push_item,
  input  logic               pop,
  output ufd_item_t          head,
  output logic               not_empty,
  output logic               full,
  output logic [Q_CNT_W-1:0] count
);

  ufd_item_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r, rd_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  assign head      = mem_r[rd_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign count     = cnt_r;

endmodule

// ===== hw/rtl/ufd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufd_back
// gathers code point bits and holds the result register
// ----------------------------------------------------------------------------
module ufd_back import ufd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  ufd_item_t       head,
  input  logic            head_valid,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CP_W-1:0] out_code_point,
  output logic            out_last_char,
  output logic            out_truncated
);

  logic [CP_W-1:0] acc_r, acc_nxt;
  logic            vld_r;
  logic [CP_W-1:0] cp_r;
  logic            last_r, trunc_r;
  logic            out_free;

  assign out_free = !vld_r || !out_stall;
  // non-emitting bytes never wait on the result side
  assign pop      = head_valid && (out_free || !head.emit);
  assign acc_nxt  = head.start ? head.contrib : (acc_r | head.contrib);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (pop && head.emit) begin
      vld_r <= 1'b1;
    end else if (!out_stall) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      acc_r <= acc_nxt;
    end
    if (pop && head.emit) begin
      cp_r    <= acc_nxt;
      last_r  <= head.last_char;
      trunc_r <= head.truncated;
    end
  end

  assign out_valid      = vld_r;
  assign out_code_point = cp_r;
  assign out_last_char  = last_r;
  assign out_truncated  = trunc_r;

endmodule

// ===== hw/rtl/utf8_stream_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// byte-serial utf-8 decoder with a five-byte lead form
// ----------------------------------------------------------------------------
// throughput: one byte per clock while in_stall is low, bounded by the single-byte classify step
// a taken byte is queued, then on its pop merged into the result shown on out_
// once the output stalls, non-emitting bytes still pass; the two-entry queue
//   takes up to two more (one at full rate) before in_stall rises
// reset: synchronous on rst_n low; clears the continuation count, the
//   queue and the result valid; payload registers are not reset
module utf8_stream_decoder_core import ufd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic            in_end_of_string,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CP_W-1:0] out_code_point,
  output logic            out_last_char,
  output logic            out_truncated
);

  ufd_item_t          front_item;   // classified request from the front
  ufd_item_t          q_head;
  logic               q_not_empty;
  logic               q_full;
  logic [Q_CNT_W-1:0] q_count;
  logic               q_pop;
  logic               take;
  logic [PEND_W-1:0]  pending;

  // the front stalls only when the queue has no room
  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  // front: tracks continuation bytes due and aligns each byte's bits
  ufd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .byte_in (in_byte),
    .eos_in  (in_end_of_string),
    .item    (front_item),
    .pending (pending)
  );

  // queue: decouples the classifier from result back-pressure
  ufd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_item (front_item),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full),
    .count     (q_count)
  );

  // back: merges bits into the code point and owns the output register
  ufd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .head_valid     (q_not_empty),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_last_char  (out_last_char),
    .out_truncated  (out_truncated)
  );

  // a truncated character is always the last of its string
  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truncated |-> out_last_char)
    else $error("truncated result without last_char");

  // a string's final byte leaves no continuation bytes pending
  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_end_of_string |=> pending == '0)
    else $error("continuation count not cleared at end of string");

  // the queue never holds more than its depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue overfilled");

  // the back only pops when the queue holds a request
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("pop from empty queue");

endmodule
